// ----- design/frd_pkg.sv -----
`default_nettype none

package frd_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam int LEN_W      = 24;
  localparam int RING_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int SLOT_OUT_W = 6;

  localparam logic [LEN_W-1:0]  BUFFER_BYTES_RST = 24'd1048576;
  localparam logic [RING_W-1:0] RING_SLOTS_RST   = 7'd64;
  localparam logic [RING_W-1:0] LAG_COUNT_RST    = 7'd1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_SYNC,
    CMD_RSVD
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EMPTY,
    ST_TOO_LARGE
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_BYTES,
    CFG_RING_SLOTS,
    CFG_LAG_COUNT
  } cfg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR_ALL,
    OP_CLR_MARKS,
    OP_WR_PREP,
    OP_WR_COMMIT,
    OP_WR_REJECT,
    OP_RD_START,
    OP_RD_PREP,
    OP_RD_TAKE,
    OP_RD_EMPTY,
    OP_RD_EXHAUST,
    OP_RD_STEP,
    OP_EMIT_ZERO
  } dp_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WR_PREP,
    S_WR_COMMIT,
    S_RD_START,
    S_RD_PREP,
    S_RD_ADDR,
    S_RD_EVAL,
    S_SYNC_CLEAR,
    S_EMIT_ZERO
  } state_t;

  typedef struct packed {
    logic clr_last;
    logic too_large;
    logic unmarked;
    logic at_write;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/frd_ctrl.sv -----
`default_nettype none

module frd_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        command,
  input  frd_pkg::dp_stat_t      stat,
  output frd_pkg::dp_op_t        op,
  output logic                   busy
);

  frd_pkg::state_t state;
  frd_pkg::state_t state_next;
  frd_pkg::cmd_t   cmd;

  assign cmd  = frd_pkg::cmd_t'(command);
  assign busy = (state != frd_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frd_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      frd_pkg::S_CLEAR: begin
        if (stat.clr_last) state_next = frd_pkg::S_IDLE;
      end
      frd_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            frd_pkg::CMD_WRITE: state_next = frd_pkg::S_WR_PREP;
            frd_pkg::CMD_READ:  state_next = frd_pkg::S_RD_START;
            frd_pkg::CMD_SYNC:  state_next = frd_pkg::S_SYNC_CLEAR;
            default:            state_next = frd_pkg::S_EMIT_ZERO;
          endcase
        end
      end
      frd_pkg::S_WR_PREP:   state_next = frd_pkg::S_WR_COMMIT;
      frd_pkg::S_WR_COMMIT: state_next = frd_pkg::S_IDLE;
      frd_pkg::S_RD_START:  state_next = frd_pkg::S_RD_PREP;
      frd_pkg::S_RD_PREP:   state_next = frd_pkg::S_RD_ADDR;
      frd_pkg::S_RD_ADDR:   state_next = frd_pkg::S_RD_EVAL;
      frd_pkg::S_RD_EVAL: begin
        if (stat.unmarked || stat.at_write || stat.scan_last) begin
          state_next = frd_pkg::S_IDLE;
        end else begin
          state_next = frd_pkg::S_RD_ADDR;
        end
      end
      frd_pkg::S_SYNC_CLEAR: begin
        if (stat.clr_last) state_next = frd_pkg::S_EMIT_ZERO;
      end
      frd_pkg::S_EMIT_ZERO: state_next = frd_pkg::S_IDLE;
      default:              state_next = frd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op = frd_pkg::OP_NONE;
    case (state)
      frd_pkg::S_CLEAR: op = frd_pkg::OP_CLR_ALL;
      frd_pkg::S_IDLE: begin
        if (start) op = frd_pkg::OP_ACCEPT;
      end
      frd_pkg::S_WR_PREP: op = frd_pkg::OP_WR_PREP;
      frd_pkg::S_WR_COMMIT: begin
        op = stat.too_large ? frd_pkg::OP_WR_REJECT : frd_pkg::OP_WR_COMMIT;
      end
      frd_pkg::S_RD_START: op = frd_pkg::OP_RD_START;
      frd_pkg::S_RD_PREP:  op = frd_pkg::OP_RD_PREP;
      frd_pkg::S_RD_ADDR:  op = frd_pkg::OP_NONE;
      frd_pkg::S_RD_EVAL: begin
        if (stat.unmarked) begin
          op = frd_pkg::OP_RD_TAKE;
        end else if (stat.at_write) begin
          op = frd_pkg::OP_RD_EMPTY;
        end else if (stat.scan_last) begin
          op = frd_pkg::OP_RD_EXHAUST;
        end else begin
          op = frd_pkg::OP_RD_STEP;
        end
      end
      frd_pkg::S_SYNC_CLEAR: op = frd_pkg::OP_CLR_MARKS;
      frd_pkg::S_EMIT_ZERO:  op = frd_pkg::OP_EMIT_ZERO;
      default:               op = frd_pkg::OP_NONE;
    endcase
  end

`ifndef SYNTHESIS
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (state == frd_pkg::S_CLEAR))
    else $error("controller did not enter the clearing pass after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_clear_to_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == frd_pkg::S_CLEAR) && stat.clr_last) |=> (state == frd_pkg::S_IDLE))
    else $error("clearing pass did not end in idle");
`endif

endmodule

`default_nettype wire

// ----- design/frd_datapath.sv -----
`default_nettype none

module frd_datapath #(
  parameter int SLOTS = frd_pkg::SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [frd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [frd_pkg::LEN_W-1:0]        cfg_data,
  input  wire logic [frd_pkg::LEN_W-1:0]        frame_length,
  input  frd_pkg::dp_op_t                       op,
  output frd_pkg::dp_stat_t                     stat,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [frd_pkg::SLOT_OUT_W-1:0]        slot,
  output logic [frd_pkg::LEN_W-1:0]             buffer_offset,
  output logic [frd_pkg::LEN_W-1:0]             length_out
);

  localparam int AW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int RW = (NW > frd_pkg::RING_W) ? NW : frd_pkg::RING_W;
  localparam int EW = ((AW > frd_pkg::RING_W) ? AW : frd_pkg::RING_W) + 1;
  localparam int LW = frd_pkg::LEN_W;
  localparam int OW = frd_pkg::SLOT_OUT_W;

  // configuration
  logic [LW-1:0]             buffer_bytes;
  logic [frd_pkg::RING_W-1:0] ring_slots;
  logic [frd_pkg::RING_W-1:0] lag_count;

  // ring state
  logic [AW-1:0] write_slot;
  logic [AW-1:0] read_slot;
  logic          read_slot_unset;
  logic          first_fill_done;
  logic [LW-1:0] fill_pointer;
  logic [AW-1:0] clr_idx;

  // working registers
  logic [LW-1:0] len_q;
  logic [LW-1:0] rest;
  logic          too_large;
  logic [AW-1:0] r;
  logic [NW-1:0] cnt;

  // descriptor and mark stores
  logic [2*LW-1:0] desc_mem [SLOTS];
  logic            mark_mem [SLOTS];
  logic [2*LW-1:0] desc_q;
  logic            mark_q;

  logic            desc_we;
  logic [AW-1:0]   desc_addr;
  logic [2*LW-1:0] desc_wd;
  logic            mark_we;
  logic [AW-1:0]   mark_addr;
  logic            mark_wd;

  // result registers
  frd_pkg::status_t status_q;
  logic [AW-1:0]    slot_q;
  logic [LW-1:0]    off_out;
  logic [LW-1:0]    len_out;
  logic [AW+OW-1:0] slot_wide;

  // derived values
  logic [RW-1:0] rs_ext;
  logic [NW-1:0] n;
  logic [AW-1:0] ws_eff;
  logic [NW-1:0] ws_inc;
  logic [AW-1:0] ws_wrap;
  logic [NW-1:0] r_inc;
  logic [AW-1:0] r_wrap;
  logic          ffd_hit;
  logic          fits;
  logic [LW-1:0] wr_off;
  logic [EW-1:0] ws_e;
  logic [EW-1:0] lag_e;
  logic [EW-1:0] n_e;
  logic [EW-1:0] diff;
  logic [AW-1:0] rs_start;
  logic [AW-1:0] rd_first;
  logic          clr_last;
  logic          load;

  assign rs_ext  = RW'(ring_slots);
  assign n       = ((rs_ext == '0) || (rs_ext > RW'(SLOTS))) ? NW'(SLOTS) : NW'(rs_ext);
  assign ws_eff  = (NW'(write_slot) < n) ? write_slot : '0;
  assign ws_inc  = NW'(ws_eff) + NW'(1);
  assign ws_wrap = (ws_inc >= n) ? '0 : AW'(ws_inc);
  assign r_inc   = NW'(r) + NW'(1);
  assign r_wrap  = (r_inc >= n) ? '0 : AW'(r_inc);
  assign ffd_hit = ((EW'(write_slot) + EW'(1)) == EW'(lag_count));
  assign fits    = (rest >= len_q);
  assign wr_off  = fits ? fill_pointer : '0;

  // start slot behind the writer, wrapped by the ring size
  assign ws_e  = EW'(write_slot);
  assign lag_e = EW'(lag_count);
  assign n_e   = EW'(n);
  assign diff  = lag_e - ws_e;
  always_comb begin
    if (ws_e >= lag_e) begin
      rs_start = AW'(ws_e - lag_e);
    end else if (diff <= n_e) begin
      rs_start = AW'(n_e - diff);
    end else begin
      rs_start = '0;
    end
  end

  assign rd_first = (NW'(read_slot) < n) ? read_slot : '0;
  assign clr_last = (clr_idx == AW'(SLOTS - 1));

  assign stat.clr_last  = clr_last;
  assign stat.too_large = too_large;
  assign stat.unmarked  = !mark_q;
  assign stat.at_write  = (r == write_slot);
  assign stat.scan_last = ((cnt + NW'(1)) == n);

  assign load = (op == frd_pkg::OP_WR_COMMIT) || (op == frd_pkg::OP_WR_REJECT) ||
                (op == frd_pkg::OP_RD_TAKE)   || (op == frd_pkg::OP_RD_EMPTY)  ||
                (op == frd_pkg::OP_RD_EXHAUST) || (op == frd_pkg::OP_EMIT_ZERO);

  // store write ports
  always_comb begin
    desc_we   = 1'b0;
    desc_addr = clr_idx;
    desc_wd   = '0;
    mark_we   = 1'b0;
    mark_addr = clr_idx;
    mark_wd   = 1'b0;
    case (op)
      frd_pkg::OP_CLR_ALL: begin
        desc_we = 1'b1;
        mark_we = 1'b1;
      end
      frd_pkg::OP_CLR_MARKS: begin
        mark_we = 1'b1;
      end
      frd_pkg::OP_WR_COMMIT: begin
        desc_we   = 1'b1;
        desc_addr = ws_eff;
        desc_wd   = {wr_off, len_q};
        mark_we   = 1'b1;
        mark_addr = ws_eff;
      end
      frd_pkg::OP_RD_TAKE: begin
        mark_we   = 1'b1;
        mark_addr = r;
        mark_wd   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (desc_we) desc_mem[desc_addr] <= desc_wd;
    desc_q <= desc_mem[r];
  end

  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_addr] <= mark_wd;
    mark_q <= mark_mem[r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_bytes    <= frd_pkg::BUFFER_BYTES_RST;
      ring_slots      <= frd_pkg::RING_SLOTS_RST;
      lag_count       <= frd_pkg::LAG_COUNT_RST;
      write_slot      <= '0;
      read_slot       <= '0;
      read_slot_unset <= 1'b1;
      first_fill_done <= 1'b0;
      fill_pointer    <= '0;
      clr_idx         <= '0;
      done            <= 1'b0;
    end else begin
      done <= load;
      if (cfg_we) begin
        case (cfg_index)
          frd_pkg::CFG_BUFFER_BYTES: buffer_bytes <= cfg_data;
          frd_pkg::CFG_RING_SLOTS:   ring_slots   <= cfg_data[frd_pkg::RING_W-1:0];
          frd_pkg::CFG_LAG_COUNT:    lag_count    <= cfg_data[frd_pkg::RING_W-1:0];
          default: begin
          end
        endcase
      end
      case (op)
        frd_pkg::OP_CLR_ALL: begin
          clr_idx <= clr_last ? '0 : clr_idx + AW'(1);
        end
        frd_pkg::OP_CLR_MARKS: begin
          clr_idx         <= clr_last ? '0 : clr_idx + AW'(1);
          read_slot_unset <= 1'b1;
        end
        frd_pkg::OP_WR_COMMIT: begin
          if (!first_fill_done && ffd_hit) first_fill_done <= 1'b1;
          fill_pointer <= fits ? (fill_pointer + len_q) : len_q;
          write_slot   <= ws_wrap;
        end
        frd_pkg::OP_RD_START: begin
          if (!first_fill_done) begin
            read_slot <= '0;
          end else if (read_slot_unset) begin
            read_slot <= rs_start;
          end
          read_slot_unset <= 1'b0;
        end
        frd_pkg::OP_RD_TAKE:    read_slot <= r_wrap;
        frd_pkg::OP_RD_EMPTY:   read_slot <= r;
        frd_pkg::OP_RD_EXHAUST: read_slot <= r_wrap;
        default: begin
        end
      endcase
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    case (op)
      frd_pkg::OP_ACCEPT: len_q <= frame_length;
      frd_pkg::OP_WR_PREP: begin
        too_large <= (len_q > buffer_bytes);
        rest      <= (fill_pointer <= buffer_bytes) ? (buffer_bytes - fill_pointer) : '0;
      end
      frd_pkg::OP_WR_COMMIT: begin
        status_q <= frd_pkg::ST_OK;
        slot_q   <= ws_eff;
        off_out  <= wr_off;
        len_out  <= len_q;
      end
      frd_pkg::OP_WR_REJECT: begin
        status_q <= frd_pkg::ST_TOO_LARGE;
        slot_q   <= ws_eff;
        off_out  <= '0;
        len_out  <= '0;
      end
      frd_pkg::OP_RD_PREP: begin
        r   <= rd_first;
        cnt <= '0;
      end
      frd_pkg::OP_RD_STEP: begin
        r   <= r_wrap;
        cnt <= cnt + NW'(1);
      end
      frd_pkg::OP_RD_TAKE: begin
        status_q <= frd_pkg::ST_OK;
        slot_q   <= r;
        off_out  <= desc_q[2*LW-1:LW];
        len_out  <= desc_q[LW-1:0];
      end
      frd_pkg::OP_RD_EMPTY: begin
        status_q <= frd_pkg::ST_EMPTY;
        slot_q   <= r;
        off_out  <= '0;
        len_out  <= '0;
      end
      frd_pkg::OP_RD_EXHAUST: begin
        status_q <= frd_pkg::ST_EMPTY;
        slot_q   <= r_wrap;
        off_out  <= '0;
        len_out  <= '0;
      end
      frd_pkg::OP_EMIT_ZERO: begin
        status_q <= frd_pkg::ST_OK;
        slot_q   <= '0;
        off_out  <= '0;
        len_out  <= '0;
      end
      default: begin
      end
    endcase
  end

  assign slot_wide     = (AW + OW)'(slot_q);
  assign slot          = slot_wide[OW-1:0];
  assign status        = status_q;
  assign buffer_offset = off_out;
  assign length_out    = len_out;

`ifndef SYNTHESIS
  a_scan_in_ring: assert property (@(posedge clk) disable iff (rst)
    ((op == frd_pkg::OP_RD_STEP) || (op == frd_pkg::OP_RD_TAKE) ||
     (op == frd_pkg::OP_RD_EMPTY) || (op == frd_pkg::OP_RD_EXHAUST)) |-> (NW'(r) < n))
    else $error("scan pointer left the ring");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (status == frd_pkg::ST_EMPTY)) |-> ((length_out == '0) && (buffer_offset == '0)))
    else $error("empty result carries a descriptor");

  a_take_ok: assert property (@(posedge clk) disable iff (rst)
    (op == frd_pkg::OP_RD_TAKE) |=> (done && (status == frd_pkg::ST_OK)))
    else $error("taken slot not reported as ok");
`endif

endmodule

`default_nettype wire

// ----- design/frame_descriptor_ring.sv -----
`default_nettype none

// Frame descriptor ring. Each request (start high while busy is low) is one
// command: write places a frame of frame_length bytes at the fill pointer, or
// at offset 0 when the rest of the buffer is short, and records it in the next
// slot, or rejects a frame longer than the buffer; read returns the next unread
// slot or reports empty; resync clears all read marks and makes the next read
// choose a fresh start slot. Every request gives exactly one result, shown for
// one cycle with done high; the receiver cannot stall, so capture it on that
// cycle. A write passes through a prepare and a commit state; a read passes
// through a start and a prepare state, then an address and an evaluate state
// for each slot the scan examines (1 up to the ring size), since the mark
// store gives registered read data. Resync sweeps every read mark, one slot
// per cycle. A new request is taken in the same cycle its predecessor's result
// is shown. After reset, busy stays high while the descriptor and mark stores
// are cleared one slot per cycle; configuration writes are taken at any time
// but belong in idle periods. Configuration uses a plain write port: cfg_we,
// cfg_index (0 buffer_bytes, 1 ring_slots, 2 lag_count) and cfg_data; other
// indexes are ignored.
module frame_descriptor_ring #(
  parameter int SLOTS = frd_pkg::SLOTS_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       command,
  input  wire logic [frd_pkg::LEN_W-1:0]        frame_length,
  input  wire logic                             cfg_we,
  input  wire logic [frd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [frd_pkg::LEN_W-1:0]        cfg_data,
  output logic                                  done,
  output logic [1:0]                            status,
  output logic [frd_pkg::SLOT_OUT_W-1:0]        slot,
  output logic [frd_pkg::LEN_W-1:0]             buffer_offset,
  output logic [frd_pkg::LEN_W-1:0]             length_out
);

  frd_pkg::dp_op_t   op;
  frd_pkg::dp_stat_t stat;

  // sequence each request through the datapath
  frd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .op      (op),
    .busy    (busy)
  );

  // hold ring pointers, configuration, descriptor and mark stores, results
  frd_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .frame_length  (frame_length),
    .op            (op),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .slot          (slot),
    .buffer_offset (buffer_offset),
    .length_out    (length_out)
  );

endmodule

`default_nettype wire

// ----- bench/frd_checker.sv -----
`timescale 1ns / 1ps

module frd_checker #(
  parameter int SLOTS = frd_pkg::SLOTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     command,
  input  logic [frd_pkg::LEN_W-1:0]      frame_length,
  input  logic                           cfg_we,
  input  logic [frd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [frd_pkg::LEN_W-1:0]      cfg_data,
  input  logic                           done,
  input  logic [1:0]                     status,
  input  logic [frd_pkg::SLOT_OUT_W-1:0] slot,
  input  logic [frd_pkg::LEN_W-1:0]      buffer_offset,
  input  logic [frd_pkg::LEN_W-1:0]      length_out,
  output int                             mismatches,
  output int                             outstanding
);

  localparam int LEN_W      = frd_pkg::LEN_W;
  localparam int RING_W     = frd_pkg::RING_W;
  localparam int CFG_IDX_W  = frd_pkg::CFG_IDX_W;
  localparam int SLOT_OUT_W = frd_pkg::SLOT_OUT_W;

  typedef struct packed {
    logic [1:0]            st;
    logic [SLOT_OUT_W-1:0] sl;
    logic [LEN_W-1:0]      off;
    logic [LEN_W-1:0]      len;
  } ring_result_t;

  logic [LEN_W-1:0]      cfg_bytes;
  logic [RING_W-1:0]     cfg_ring;
  logic [RING_W-1:0]     cfg_lag;

  logic [SLOT_OUT_W-1:0] wr_slot;
  logic [SLOT_OUT_W-1:0] rd_slot;
  logic                  rd_unset;
  logic                  fill_reached;
  logic [LEN_W-1:0]      fill_ptr;
  logic [LEN_W-1:0]      desc_off [SLOTS];
  logic [LEN_W-1:0]      desc_len [SLOTS];
  logic                  consumed [SLOTS];

  ring_result_t          results_due [$];
  ring_result_t          seen;

  function automatic int ring_size();
    return (cfg_ring == 0 || cfg_ring > SLOTS) ? SLOTS : int'(cfg_ring);
  endfunction

  function automatic ring_result_t pack_result(input logic [1:0] st, input int sl,
                                               input logic [LEN_W-1:0] off,
                                               input logic [LEN_W-1:0] len);
    ring_result_t r;
    r.st  = st;
    r.sl  = SLOT_OUT_W'(sl);
    r.off = off;
    r.len = len;
    return r;
  endfunction

  function automatic ring_result_t place_frame(input logic [LEN_W-1:0] len);
    int n;
    int ws;
    logic [LEN_W-1:0] room;
    logic [LEN_W-1:0] off;
    n  = ring_size();
    ws = (wr_slot < n) ? int'(wr_slot) : 0;
    if (len > cfg_bytes) return pack_result(frd_pkg::ST_TOO_LARGE, ws, '0, '0);
    if (!fill_reached && int'(wr_slot) + 1 == int'(cfg_lag)) fill_reached = 1'b1;
    room = (fill_ptr <= cfg_bytes) ? cfg_bytes - fill_ptr : '0;
    if (room >= len) begin
      off      = fill_ptr;
      fill_ptr = fill_ptr + len;
    end else begin
      off      = '0;
      fill_ptr = len;
    end
    desc_off[ws] = off;
    desc_len[ws] = len;
    consumed[ws] = 1'b0;
    ws++;
    if (ws >= n) ws = 0;
    wr_slot = SLOT_OUT_W'(ws);
    return pack_result(frd_pkg::ST_OK, ((ws == 0) ? n : ws) - 1, off, len);
  endfunction

  function automatic ring_result_t take_unread();
    int n;
    int lag;
    int ws;
    int r;
    int i;
    n   = ring_size();
    lag = int'(cfg_lag);
    ws  = int'(wr_slot);
    if (!fill_reached) begin
      rd_slot  = '0;
      rd_unset = 1'b0;
    end else if (rd_unset) begin
      if (ws >= lag) rd_slot = SLOT_OUT_W'(ws - lag);
      else if (lag - ws <= n) rd_slot = SLOT_OUT_W'(n - (lag - ws));
      else rd_slot = '0;
      rd_unset = 1'b0;
    end
    r = (rd_slot < n) ? int'(rd_slot) : 0;
    for (i = 0; i < n; i++) begin
      if (!consumed[r]) begin
        consumed[r] = 1'b1;
        rd_slot     = SLOT_OUT_W'((r + 1 >= n) ? 0 : r + 1);
        return pack_result(frd_pkg::ST_OK, r, desc_off[r], desc_len[r]);
      end
      if (r == ws) begin
        rd_slot = SLOT_OUT_W'(r);
        return pack_result(frd_pkg::ST_EMPTY, r, '0, '0);
      end
      r = (r + 1 >= n) ? 0 : r + 1;
    end
    rd_slot = SLOT_OUT_W'(r);
    return pack_result(frd_pkg::ST_EMPTY, r, '0, '0);
  endfunction

  function automatic ring_result_t ring_step(input logic [1:0] cmd,
                                             input logic [LEN_W-1:0] len);
    int i;
    case (frd_pkg::cmd_t'(cmd))
      frd_pkg::CMD_WRITE: return place_frame(len);
      frd_pkg::CMD_READ:  return take_unread();
      frd_pkg::CMD_SYNC: begin
        rd_unset = 1'b1;
        for (i = 0; i < SLOTS; i++) consumed[i] = 1'b0;
        return pack_result(frd_pkg::ST_OK, 0, '0, '0);
      end
      default:   return pack_result(frd_pkg::ST_OK, 0, '0, '0);
    endcase
  endfunction

  task automatic clear_model();
    int i;
    cfg_bytes    = frd_pkg::BUFFER_BYTES_RST;
    cfg_ring     = frd_pkg::RING_SLOTS_RST;
    cfg_lag      = frd_pkg::LAG_COUNT_RST;
    wr_slot      = '0;
    rd_slot      = '0;
    rd_unset     = 1'b1;
    fill_reached = 1'b0;
    fill_ptr     = '0;
    for (i = 0; i < SLOTS; i++) begin
      desc_off[i] = '0;
      desc_len[i] = '0;
      consumed[i] = 1'b0;
    end
    results_due.delete();
  endtask

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    case (frd_pkg::cfg_idx_t'(idx))
      frd_pkg::CFG_BUFFER_BYTES: cfg_bytes = data;
      frd_pkg::CFG_RING_SLOTS:   cfg_ring  = data[RING_W-1:0];
      frd_pkg::CFG_LAG_COUNT:    cfg_lag   = data[RING_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("%0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_result(input ring_result_t got, input ring_result_t want);
    if (got.st !== want.st)
      report_mismatch($sformatf("status got %0d want %0d (slot %0d)", got.st, want.st, want.sl));
    if (got.sl !== want.sl)
      report_mismatch($sformatf("slot got %0d want %0d", got.sl, want.sl));
    if (got.off !== want.off)
      report_mismatch($sformatf("buffer_offset got %0h want %0h (slot %0d)",
                                got.off, want.off, want.sl));
    if (got.len !== want.len)
      report_mismatch($sformatf("length_out got %0h want %0h (slot %0d)",
                                got.len, want.len, want.sl));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_model();
      mismatches = 0;
    end else begin
      if (done) begin
        seen.st  = status;
        seen.sl  = slot;
        seen.off = buffer_offset;
        seen.len = length_out;
        if (results_due.size() == 0) report_mismatch("result with no request waiting");
        else compare_result(seen, results_due.pop_front());
      end
      if (cfg_we) apply_config(cfg_index, cfg_data);
      if (start && !busy) results_due.push_back(ring_step(command, frame_length));
    end
    outstanding = results_due.size();
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS      = frd_pkg::SLOTS_DEFAULT;
  localparam int LEN_W      = frd_pkg::LEN_W;
  localparam int RING_W     = frd_pkg::RING_W;
  localparam int CFG_IDX_W  = frd_pkg::CFG_IDX_W;
  localparam int SLOT_OUT_W = frd_pkg::SLOT_OUT_W;
  // Longest read scan plus some margin; used for the tail after the last result.
  localparam int TAIL_CYCLES = 2 * SLOTS + 16;
  // Index that no register answers to; the block must ignore it.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 132;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [1:0]            command;
  logic [LEN_W-1:0]      frame_length;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [LEN_W-1:0]      cfg_data;
  logic                  done;
  logic [1:0]            status;
  logic [SLOT_OUT_W-1:0] slot;
  logic [LEN_W-1:0]      buffer_offset;
  logic [LEN_W-1:0]      length_out;

  int                    mismatches;
  int                    outstanding;

  // Stimulus shaping: chance in percent of a sender gap before each request,
  // and the current buffer and ring size so lengths and bursts fit the setting.
  int                    idle_pct;
  logic [LEN_W-1:0]      cur_bytes;
  int                    cur_ring;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  frame_descriptor_ring #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .frame_length(frame_length),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .slot(slot),
    .buffer_offset(buffer_offset),
    .length_out(length_out)
  );

  frd_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .frame_length(frame_length),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .status(status),
    .slot(slot),
    .buffer_offset(buffer_offset),
    .length_out(length_out),
    .mismatches(mismatches),
    .outstanding(outstanding)
  );

  // Issue one request. Every task here is entered and left just after a falling
  // edge, so busy is stable when looked at and inputs never move near a rising
  // edge. Start stays high across back-to-back requests: only one assignment
  // to it per falling edge.
  task automatic send_request(input frd_pkg::cmd_t cmd, input logic [LEN_W-1:0] len);
    int gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      // Mostly short gaps that land inside a busy stretch, sometimes long ones
      // that outlast a full scan so the block sits idle with nothing to do.
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 140) : $urandom_range(1, 12);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    command      <= cmd;
    frame_length <= len;
    // Hold the request until busy is low; it is taken at the next rising edge.
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  // Drop start and wait until every request has its result back.
  task automatic wait_drain();
    start <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
  endtask

  // Write all three registers back to back. The ring and lag registers are
  // narrow: fill the unused upper data bits with noise, the block keeps only
  // the low bits.
  task automatic load_config(input logic [LEN_W-1:0] bytes, input logic [RING_W-1:0] ring,
                             input logic [RING_W-1:0] lag);
    logic [LEN_W-1:0] word;
    write_register(frd_pkg::CFG_BUFFER_BYTES, bytes);
    word = LEN_W'($urandom);
    word[RING_W-1:0] = ring;
    write_register(frd_pkg::CFG_RING_SLOTS, word);
    word = LEN_W'($urandom);
    word[RING_W-1:0] = lag;
    write_register(frd_pkg::CFG_LAG_COUNT, word);
    cfg_we    <= 1'b0;
    cur_bytes = bytes;
    cur_ring  = (ring == 0 || ring > SLOTS) ? SLOTS : int'(ring);
  endtask

  // Frame lengths: mostly frames that fit a few times over, plus the edges
  // around the buffer size, zero, all ones and fully random values.
  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LEN_W'($urandom);
      3:       return cur_bytes + LEN_W'($urandom_range(0, 2));
      4:       return cur_bytes - LEN_W'($urandom_range(0, 2));
      default: return LEN_W'($urandom_range(0, cur_bytes / 3));
    endcase
  endfunction

  // Mostly bursts of writes followed by reads, so reads find real frames and
  // the ring wraps; the rest is single commands of any kind as noise.
  task automatic random_phase(input int items);
    int sent;
    int writes;
    int reads;
    int k;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        // Trim the burst to what is left of the phase.
        writes = $urandom_range(1, cur_ring + 2);
        if (writes > items - sent) writes = items - sent;
        reads  = $urandom_range(1, cur_ring + 3);
        if (reads > items - sent - writes) reads = items - sent - writes;
        for (k = 0; k < writes; k++) send_request(frd_pkg::CMD_WRITE, pick_length());
        if ($urandom_range(0, 4) == 0) begin
          send_request(frd_pkg::CMD_SYNC, LEN_W'($urandom));
          sent++;
        end
        for (k = 0; k < reads; k++) send_request(frd_pkg::CMD_READ, LEN_W'($urandom));
        sent += writes + reads;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            send_request(frd_pkg::CMD_WRITE, pick_length());
            sent++;
          end
          1: begin
            send_request(frd_pkg::CMD_READ, LEN_W'($urandom));
            sent++;
          end
          2: begin
            send_request(frd_pkg::CMD_SYNC, LEN_W'($urandom));
            sent++;
          end
          default: begin
            send_request(frd_pkg::CMD_RSVD, LEN_W'($urandom));
            sent++;
          end
        endcase
      end
      // Now and then let the ring go completely quiet mid-phase.
      if ($urandom_range(0, 59) == 0) wait_drain();
    end
  endtask

  initial begin
    int p;
    logic [LEN_W-1:0] bytes;
    logic [RING_W-1:0] ring;
    logic [RING_W-1:0] lag;

    rst          = 1'b1;
    start        = 1'b0;
    command      = frd_pkg::CMD_WRITE;
    frame_length = '0;
    cfg_we       = 1'b0;
    cfg_index    = frd_pkg::CFG_BUFFER_BYTES;
    cfg_data     = '0;
    idle_pct     = 0;
    cur_bytes    = frd_pkg::BUFFER_BYTES_RST;
    cur_ring     = SLOTS;

    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // Wait out the store clearing pass after reset.
    while (busy) @(negedge clk);

    // Reset settings: read of a never written slot before the first fill,
    // the unused command, an oversized frame, the write that completes the
    // first fill, and a resync followed by a read from the lagged start.
    send_request(frd_pkg::CMD_READ, '0);
    send_request(frd_pkg::CMD_RSVD, '1);
    send_request(frd_pkg::CMD_WRITE, '1);
    send_request(frd_pkg::CMD_WRITE, '0);
    send_request(frd_pkg::CMD_READ, '1);
    send_request(frd_pkg::CMD_SYNC, '0);
    send_request(frd_pkg::CMD_READ, '0);
    wait_drain();

    // Small buffer and ring: exact fit, wrap to offset 0 on a short rest,
    // one byte too many, and a run of reads.
    write_register(CFG_UNUSED, LEN_W'($urandom));
    load_config(24'd1000, 7'd8, 7'd2);
    send_request(frd_pkg::CMD_WRITE, 24'd1000);
    send_request(frd_pkg::CMD_WRITE, 24'd1);
    send_request(frd_pkg::CMD_WRITE, 24'd1001);
    send_request(frd_pkg::CMD_WRITE, 24'd300);
    send_request(frd_pkg::CMD_WRITE, 24'd300);
    repeat (5) send_request(frd_pkg::CMD_READ, '0);
    send_request(frd_pkg::CMD_SYNC, '0);
    send_request(frd_pkg::CMD_READ, '0);
    wait_drain();

    // Shrink the ring under the write slot and the buffer under the fill
    // pointer, with a lag past the ring.
    load_config(24'd50, 7'd3, 7'd127);
    repeat (4) send_request(frd_pkg::CMD_READ, '0);
    send_request(frd_pkg::CMD_WRITE, 24'd10);
    send_request(frd_pkg::CMD_WRITE, 24'd50);
    send_request(frd_pkg::CMD_READ, '0);
    wait_drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0:  begin bytes = 24'd1;        ring = 7'd1;   lag = 7'd0;   end
        1:  begin bytes = 24'hFFFFFF;   ring = 7'd64;  lag = 7'd64;  end
        2:  begin bytes = 24'hFFFFFF;   ring = 7'd0;   lag = 7'd1;   end
        3:  begin bytes = 24'd300;      ring = 7'd5;   lag = 7'd3;   end
        4:  begin bytes = 24'd5000;     ring = 7'd16;  lag = 7'd20;  end
        5:  begin bytes = 24'd1000000;  ring = 7'd2;   lag = 7'd1;   end
        6:  begin bytes = 24'd65535;    ring = 7'd100; lag = 7'd127; end
        7:  begin bytes = LEN_W'($urandom); ring = RING_W'($urandom_range(0, 127));
                  lag = RING_W'($urandom_range(0, 127)); end
        8:  begin bytes = 24'd4096;     ring = 7'd64;  lag = 7'd0;   end
        9:  begin bytes = 24'd777;      ring = 7'd3;   lag = 7'd66;  end
        default: begin bytes = LEN_W'($urandom_range(1, 24'hFFFFFF));
                  ring = RING_W'($urandom_range(0, 64));
                  lag = RING_W'($urandom_range(0, 64)); end
      endcase
      // Rotate the sender pattern: steady, mostly idle, lightly idle.
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 60;
        default: idle_pct = 10;
      endcase
      wait_drain();
      load_config(bytes, ring, lag);
      random_phase(PHASE_ITEMS);
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run (about ten times the worst case
  // of a full scan plus the longest sender gap on every request).
  initial begin
    #40_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
